// ===== rtl/core/isq_pkg.sv =====
package isq_pkg;

  // Default build
  localparam int unsigned DefCapacity  = 64;
  localparam int unsigned DefElemWidth = 32;

  // Fixed field widths on the ports
  localparam int unsigned ModeW   = 3;
  localparam int unsigned PosW    = 7;
  localparam int unsigned DataW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 7;

  // Operation codes (codes above MODE_CLEAR are no-ops)
  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 3'd0,
    MODE_GET    = 3'd1,
    MODE_UPDATE = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_CLEAR  = 3'd4
  } isq_mode_e;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } isq_status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MOVE,
    ST_DONE
  } isq_state_e;

endpackage

// ===== rtl/core/isq_ram.sv =====
module isq_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/indexed_sequence_store.sv =====
// Ordered store of up to CAPACITY elements addressed by position, backed by one
// single-port-write, registered-read RAM. Each beat on the input asks for insert,
// get, update, remove or clear and returns exactly one result beat carrying a
// status, the data read and the new element count. Insert and remove move the
// later elements through the RAM one per cycle, a rate that the single RAM port
// pair sets. The input is stalled while an item is in work; a finished result
// waits in the output register while the next beat is taken. No clearing pass
// is needed after reset.
module indexed_sequence_store #(
  parameter int unsigned CAPACITY   = isq_pkg::DefCapacity,
  parameter int unsigned ELEM_WIDTH = isq_pkg::DefElemWidth
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [isq_pkg::ModeW-1:0]   mode_i,
  input  logic [isq_pkg::PosW-1:0]    position_i,
  input  logic [isq_pkg::DataW-1:0]   write_data_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [isq_pkg::StatusW-1:0] status_o,
  output logic [isq_pkg::DataW-1:0]   read_data_o,
  output logic [isq_pkg::CountW-1:0]  entry_count_o
);

  import isq_pkg::*;

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);
  localparam int unsigned CW   = (CNTW > PosW) ? CNTW : PosW;
  localparam int unsigned DW   = (ELEM_WIDTH > DataW) ? ELEM_WIDTH : DataW;

  // sequencer and control
  isq_state_e        state_q, state_d;
  logic [ModeW-1:0]  mode_q;
  logic              ok_q;
  isq_status_e       status_q;
  logic [AW-1:0]     pos_q;
  logic [ELEM_WIDTH-1:0] data_q;
  logic [CNTW-1:0]   count_q, count_d;
  logic [AW-1:0]     src_q, src_d;
  logic [CNTW-1:0]   moves_q, moves_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pend_addr_q, pend_addr_d;

  // output register
  logic                  out_valid_q;
  logic [StatusW-1:0]    status_out_q;
  logic [DataW-1:0]      rdata_out_q;
  logic [CountW-1:0]     count_out_q;

  // RAM port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [ELEM_WIDTH-1:0] mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [ELEM_WIDTH-1:0] mem_rdata;

  // decode of the incoming beat
  logic              in_fire;
  logic              out_free;
  logic              done_fire;
  logic [CW-1:0]     pos_ext, cnt_ext;
  logic [CW-1:0]     ins_moves_ext, rem_moves_ext;
  logic [CW-1:0]     rem_src_ext;
  logic              dec_ok;
  isq_status_e       dec_status;
  logic [CNTW-1:0]   dec_moves;
  logic [AW-1:0]     dec_src;
  logic [DW-1:0]     wd_ext;
  logic [DW-1:0]     rd_ext;
  logic [CW-1:0]     cnt_new_ext;
  logic              is_insert;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign done_fire  = (state_q == ST_DONE) && out_free;
  assign is_insert  = (mode_q == MODE_INSERT);

  assign pos_ext       = CW'(position_i);
  assign cnt_ext       = CW'(count_q);
  assign ins_moves_ext = cnt_ext - pos_ext;
  assign rem_moves_ext = cnt_ext - pos_ext - CW'(1);
  assign rem_src_ext   = pos_ext + CW'(1);
  assign wd_ext        = DW'(write_data_i);

  // range and capacity checks on the incoming beat
  always_comb begin
    dec_ok     = 1'b0;
    dec_status = STATUS_OK;
    dec_moves  = '0;
    dec_src    = '0;
    unique case (mode_i)
      MODE_INSERT: begin
        if (pos_ext > cnt_ext) begin
          dec_status = STATUS_RANGE;
        end else if (count_q == CNTW'(CAPACITY)) begin
          dec_status = STATUS_FULL;
        end else begin
          dec_ok    = 1'b1;
          dec_moves = ins_moves_ext[CNTW-1:0];
          dec_src   = AW'(count_q - CNTW'(1));
        end
      end
      MODE_GET, MODE_UPDATE: begin
        if (pos_ext >= cnt_ext) begin
          dec_status = STATUS_RANGE;
        end else begin
          dec_ok = 1'b1;
        end
      end
      MODE_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          dec_status = STATUS_RANGE;
        end else begin
          dec_ok    = 1'b1;
          dec_moves = rem_moves_ext[CNTW-1:0];
          dec_src   = rem_src_ext[AW-1:0];
        end
      end
      default: begin
        dec_ok = 1'b1;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (dec_ok && (dec_moves != '0) &&
              (mode_i == MODE_INSERT || mode_i == MODE_REMOVE)) begin
            state_d = ST_MOVE;
          end else if (dec_ok && mode_i == MODE_GET) begin
            state_d = ST_READ;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: state_d = ST_DONE;
      ST_MOVE: begin
        if (moves_q == '0 && !pend_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // move engine, RAM port and count update
  always_comb begin
    src_d       = src_q;
    moves_d     = moves_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    count_d     = count_q;
    mem_we      = 1'b0;
    mem_waddr   = pend_addr_q;
    mem_wdata   = mem_rdata;
    mem_raddr   = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          src_d   = dec_src;
          moves_d = dec_moves;
        end
      end
      ST_MOVE: begin
        mem_raddr = src_q;
        // finish the move whose data came out of the RAM this cycle
        if (pend_q) begin
          mem_we = 1'b1;
        end
        if (moves_q != '0) begin
          moves_d     = moves_q - CNTW'(1);
          pend_d      = 1'b1;
          pend_addr_d = is_insert ? (src_q + AW'(1)) : (src_q - AW'(1));
          src_d       = is_insert ? (src_q - AW'(1)) : (src_q + AW'(1));
        end
      end
      ST_DONE: begin
        if (done_fire) begin
          if (ok_q && (mode_q == MODE_INSERT || mode_q == MODE_UPDATE)) begin
            mem_we    = 1'b1;
            mem_waddr = pos_q;
            mem_wdata = data_q;
          end
          if (ok_q && mode_q == MODE_INSERT) begin
            count_d = count_q + CNTW'(1);
          end else if (ok_q && mode_q == MODE_REMOVE) begin
            count_d = count_q - CNTW'(1);
          end else if (mode_q == MODE_CLEAR) begin
            count_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  assign rd_ext      = DW'(mem_rdata);
  assign cnt_new_ext = CW'(count_d);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      moves_q     <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      moves_q <= moves_d;
      pend_q  <= pend_d;
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    src_q       <= src_d;
    pend_addr_q <= pend_addr_d;
    if (in_fire) begin
      mode_q   <= mode_i;
      ok_q     <= dec_ok;
      status_q <= dec_status;
      pos_q    <= pos_ext[AW-1:0];
      data_q   <= wd_ext[ELEM_WIDTH-1:0];
    end
    if (done_fire) begin
      status_out_q <= status_q;
      rdata_out_q  <= (ok_q && mode_q == MODE_GET) ? rd_ext[DataW-1:0] : '0;
      count_out_q  <= cnt_new_ext[CountW-1:0];
    end
  end

  isq_ram #(
    .Depth (CAPACITY),
    .Width (ELEM_WIDTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_out_q;
  assign read_data_o   = rdata_out_q;
  assign entry_count_o = count_out_q;

  // the count never passes the capacity
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNTW'(CAPACITY))
    else $error("element count above capacity");

  // the count only changes when a result is produced
  a_count_at_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> $past(done_fire))
    else $error("element count changed outside result step");

  // RAM is written only while moving or finishing an item
  a_write_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_MOVE || state_q == ST_DONE))
    else $error("RAM write outside move or finish");

  // a new result beat appears only after the finish step
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result beat without finish step");

  // the move engine is drained before the finish step
  a_move_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (!pend_q && moves_q == '0))
    else $error("finish step with moves outstanding");

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import isq_pkg::*;

  localparam int unsigned Cap        = DefCapacity;
  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned LongHold   = 400;
  localparam int unsigned Chunks     = 10;
  localparam int unsigned ChunkItems = 95;

  // mode codes above clear do nothing
  localparam logic [ModeW-1:0] ModeUnusedLo = ModeW'(int'(MODE_CLEAR) + 1);
  localparam logic [ModeW-1:0] ModeUnusedHi = '1;
  localparam logic [PosW-1:0]  PosTop       = '1;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [DataW-1:0]   read_data;
    logic [CountW-1:0]  entry_count;
  } result_t;

  // Shadow copy of the sequence plus the queue of results it implies
  class seq_mirror;
    logic [DefElemWidth-1:0] elems [Cap];
    int unsigned held;
    int unsigned peak;
    int unsigned full_hits;
    int unsigned range_hits;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned errors;
    result_t     expected_results [$];

    function new();
      held = 0;
      peak = 0;
      full_hits = 0;
      range_hits = 0;
      beats_in = 0;
      beats_out = 0;
      errors = 0;
    endfunction

    task flag_mismatch(string what, logic [DataW-1:0] got, logic [DataW-1:0] want);
      errors++;
      $display("%0t: result %0d %s got %0h want %0h", $time, beats_out, what, got, want);
    endtask

    // apply one accepted item and queue the result it must produce
    function void note_beat(logic [ModeW-1:0] m, logic [PosW-1:0] p, logic [DataW-1:0] d);
      result_t     r;
      int unsigned i;
      r.status    = STATUS_OK;
      r.read_data = '0;
      beats_in++;
      case (m)
        MODE_INSERT: begin
          if (p > held) begin
            r.status = STATUS_RANGE;
          end else if (held >= Cap) begin
            r.status = STATUS_FULL;
          end else begin
            for (i = held; i > p; i--) elems[i] = elems[i-1];
            elems[p] = DefElemWidth'(d);
            held++;
          end
        end
        MODE_GET: begin
          if (p >= held) r.status = STATUS_RANGE;
          else r.read_data = DataW'(elems[p]);
        end
        MODE_UPDATE: begin
          if (p >= held) r.status = STATUS_RANGE;
          else elems[p] = DefElemWidth'(d);
        end
        MODE_REMOVE: begin
          if (p >= held) begin
            r.status = STATUS_RANGE;
          end else begin
            for (i = p; i + 1 < held; i++) elems[i] = elems[i+1];
            held--;
          end
        end
        MODE_CLEAR: held = 0;
        default: ;
      endcase
      if (r.status == STATUS_RANGE) range_hits++;
      if (r.status == STATUS_FULL) full_hits++;
      if (held > peak) peak = held;
      r.entry_count = CountW'(held);
      expected_results.push_back(r);
    endfunction

    task check_beat(logic [StatusW-1:0] st, logic [DataW-1:0] rd, logic [CountW-1:0] cnt);
      result_t want;
      beats_out++;
      if (expected_results.size() == 0) begin
        flag_mismatch("arrived with nothing outstanding", rd, '0);
        return;
      end
      want = expected_results.pop_front();
      if (st !== want.status) flag_mismatch("status", DataW'(st), DataW'(want.status));
      if (rd !== want.read_data) flag_mismatch("read_data", rd, want.read_data);
      if (cnt !== want.entry_count)
        flag_mismatch("entry_count", DataW'(cnt), DataW'(want.entry_count));
    endtask
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [ModeW-1:0]    mode_i;
  logic [PosW-1:0]     position_i;
  logic [DataW-1:0]    write_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [StatusW-1:0]  status_o;
  logic [DataW-1:0]    read_data_o;
  logic [CountW-1:0]   entry_count_o;

  seq_mirror   sb;
  bit          tx_idle_en;
  bit          rx_idle_en;
  bit          long_hold_req;
  int unsigned quiet_cycles;

  indexed_sequence_store dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .mode_i        (mode_i),
    .position_i    (position_i),
    .write_data_i  (write_data_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_data_o   (read_data_o),
    .entry_count_o (entry_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        out_stall_i <= 1'b0;
        long_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_stall_i == 1'b0)
        sb.check_beat(status_o, read_data_o, entry_count_o);
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("watchdog: no beat for %0d cycles", quiet_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // offer one beat, hold it until taken, then maybe leave a gap
  task automatic send_item(logic [ModeW-1:0] m, logic [PosW-1:0] p, logic [DataW-1:0] d);
    in_valid_i   <= 1'b1;
    mode_i       <= m;
    position_i   <= p;
    write_data_i <= d;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    sb.note_beat(m, p, d);
    if (tx_idle_en && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  // stop offering until every queued result has been seen
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.expected_results.size() != 0);
  endtask

  initial begin
    int unsigned chunk;
    int unsigned n;
    int unsigned r;
    int unsigned s;
    int unsigned ins_w;
    int unsigned rem_w;
    logic [ModeW-1:0] m;
    logic [PosW-1:0]  p;

    sb = new();
    quiet_cycles = 0;
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    long_hold_req = 1'b0;
    rst_ni       <= 1'b0;
    in_valid_i   <= 1'b0;
    mode_i       <= MODE_INSERT;
    position_i   <= '0;
    write_data_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty store, ends, middle, only element, no-op codes, clear
    send_item(MODE_GET,    7'd0, '0);
    send_item(MODE_REMOVE, 7'd0, '0);
    send_item(MODE_UPDATE, 7'd0, '1);
    send_item(MODE_INSERT, 7'd1, '1);
    send_item(MODE_INSERT, 7'd0, 32'hFFFF_FFFF);
    send_item(MODE_INSERT, 7'd0, 32'h0000_0000);
    send_item(MODE_INSERT, 7'd2, 32'hA5A5_A5A5);
    send_item(MODE_INSERT, 7'd1, 32'h5A5A_5A5A);
    send_item(MODE_GET,    7'd0, '0);
    send_item(MODE_GET,    7'd1, '0);
    send_item(MODE_GET,    7'd2, '0);
    send_item(MODE_GET,    7'd3, '0);
    send_item(MODE_GET,    7'd4, '0);
    send_item(MODE_GET,    PosTop, '0);
    send_item(MODE_UPDATE, 7'd3, 32'h1234_5678);
    send_item(MODE_REMOVE, 7'd1, '0);
    send_item(MODE_REMOVE, 7'd0, '0);
    send_item(MODE_REMOVE, 7'd1, '0);
    send_item(MODE_GET,    7'd0, '0);
    send_item(MODE_REMOVE, 7'd0, '0);
    send_item(ModeUnusedLo, PosTop, '1);
    send_item(ModeUnusedHi, PosTop, '1);
    send_item(MODE_INSERT, 7'd0, 32'hDEAD_BEEF);
    send_item(MODE_CLEAR,  PosTop, '1);
    drain();

    // fill to capacity, then probe the full-store boundary
    while (sb.held < Cap)
      send_item(MODE_INSERT, PosW'($urandom_range(0, sb.held)), $urandom);
    send_item(MODE_INSERT, PosW'(Cap), $urandom);
    send_item(MODE_INSERT, PosW'(Cap + 1), $urandom);
    send_item(MODE_INSERT, PosTop, $urandom);
    send_item(MODE_INSERT, 7'd0, $urandom);
    send_item(MODE_GET,    PosW'(Cap - 1), '0);
    send_item(MODE_GET,    PosW'(Cap), '0);
    send_item(MODE_UPDATE, PosW'(Cap - 1), '1);
    send_item(MODE_REMOVE, PosW'(Cap - 1), '0);
    send_item(MODE_REMOVE, 7'd0, '0);
    drain();

    // random chunks, with the idling profile and insert/remove mix varied by chunk number
    for (chunk = 0; chunk < Chunks; chunk++) begin
      if (chunk >= Chunks - 2) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end else begin
        tx_idle_en = (chunk % 4 == 0) || (chunk % 4 == 1);
        rx_idle_en = (chunk % 4 == 0) || (chunk % 4 == 2);
      end
      if (chunk == 2) long_hold_req = 1'b1;
      ins_w = (chunk % 2 == 0) ? 40 : 15;
      rem_w = (chunk % 2 == 0) ? 10 : 35;
      for (n = 0; n < ChunkItems; n++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          m = ModeW'($urandom_range(0, int'(MODE_CLEAR)));
          p = PosW'($urandom_range(0, int'(PosTop)));
        end else if (r < 11) begin
          m = ModeW'($urandom_range(int'(ModeUnusedLo), int'(ModeUnusedHi)));
          p = PosW'($urandom_range(0, int'(PosTop)));
        end else if (r < 13) begin
          m = MODE_CLEAR;
          p = PosW'($urandom_range(0, int'(PosTop)));
        end else begin
          s = $urandom_range(0, ins_w + rem_w + 39);
          if (s < ins_w) begin
            m = MODE_INSERT;
            p = PosW'($urandom_range(0, sb.held));
          end else begin
            if (s < ins_w + rem_w) m = MODE_REMOVE;
            else if (s < ins_w + rem_w + 25) m = MODE_GET;
            else m = MODE_UPDATE;
            p = (sb.held == 0) ? '0 : PosW'($urandom_range(0, sb.held - 1));
          end
        end
        send_item(m, p, $urandom);
      end
      drain();
    end

    repeat (80) @(posedge clk_i);
    $display("covered %0d beats in, %0d results out, peak fill %0d of %0d",
             sb.beats_in, sb.beats_out, sb.peak, Cap);
    $display("rejects seen: %0d bad position, %0d store full; %0d mismatches",
             sb.range_hits, sb.full_hits, sb.errors);
    if (sb.errors == 0 && sb.expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== indexed_sequence_store.f =====
rtl/core/isq_pkg.sv
rtl/core/isq_ram.sv
rtl/core/indexed_sequence_store.sv
bench/tb.sv
